>>> src/rtd_pkg.sv
// Shared widths, constants and sideband types for the RTD code-to-temperature block.
// No dependencies; rtd_if, rtd_poly, the top level and the testbench use this package.
package rtd_pkg;

  localparam int unsigned REF_W      = 18;
  localparam int unsigned NOM_W      = 16;
  localparam int unsigned TEMP_W     = 19;
  localparam int unsigned RES_W      = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_REF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM = 2'd1;

  localparam logic [REF_W-1:0] REF_RESET = 18'd6880;
  localparam logic [NOM_W-1:0] NOM_RESET = 16'd1600;

  // R/R0 in Q24, clipped once it passes 17.0
  localparam int unsigned RQ_FRAC = 24;
  localparam int unsigned RQ_W    = 29;
  localparam logic [RQ_W-1:0] RQ_CLIP = 29'd285212672;
  localparam int unsigned UQ_W    = 30;
  localparam logic signed [UQ_W-1:0] UQ_ONE = 30'sd16777216;
  localparam logic signed [UQ_W-1:0] UQ_MIN = -30'sd268435456;

  // polynomial variable: 100*R/R0 in Q12, clipped to 512 ohm
  localparam int unsigned XNUM_W = 37;
  localparam int unsigned X_MUL  = 25;
  localparam int unsigned X_SH   = 14;
  localparam int unsigned X_W    = 22;
  localparam logic [X_W-1:0] X_MAX = 22'd2097152;

  // root argument of the quadratic, scaled by 1e14 * 2^24
  localparam logic signed [28:0] CVD_4B = 29'sd231000000;
  localparam int unsigned Y_W     = 59;
  localparam logic signed [Y_W-1:0] Y_BASE = 59'sd1527480889 <<< 24;
  localparam int unsigned SQ_IN_W = 56;
  localparam int unsigned S_W     = 28;
  localparam logic [S_W-1:0] CVD_AS = 28'd160083968;

  // quadratic branch: (1000*a + 92400) / 184800 taken as ((5*a + 462) >> 2) / 231,
  // the last step as a multiply by ceil(2^36 / 231), exact below 2^28
  localparam int unsigned WN_W       = 31;
  localparam logic [WN_W-1:0] Q_BIAS = 31'd462;
  localparam int unsigned QW_W       = 28;
  localparam int unsigned Q_RECIP_SH = 36;
  localparam logic [28:0] Q_RECIP    = 29'd297486913;
  localparam int unsigned QP_W       = 57;
  localparam int unsigned TQ_W       = 18;

  localparam logic signed [TEMP_W-1:0] T_MAX = 19'sd262143;
  localparam logic signed [TEMP_W-1:0] T_MIN = -19'sd65536;

  // Horner evaluation of the low-range polynomial
  localparam int unsigned POLY_N  = 5;
  localparam int unsigned ACC_W   = 44;
  localparam int unsigned PROD_W  = ACC_W + X_W + 1;
  localparam int unsigned TP_W    = 26;
  localparam int unsigned ROUND_SH = 18;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 44'sd131072;
  localparam logic signed [ACC_W-1:0] POLY_K [POLY_N+1] = '{
    44'sd719830322984, -44'sd259942294115, -44'sd86937487207,
    44'sd45491633892, 44'sd76374826444, -44'sd16241687265
  };
  localparam int unsigned POLY_SH [POLY_N] = '{21, 21, 22, 21, 21};

  typedef struct packed {
    logic [RES_W-1:0]  res;
    logic [XNUM_W-1:0] xnum;
  } div1_side_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic [RQ_W-1:0]  rq;
    logic             rq_ovf;
  } div2_side_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic [X_W-1:0]   x;
    logic             y_nonneg;
  } sqrt_side_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic [X_W-1:0]   x;
    logic             quad;
  } div3_side_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    logic             quad;
    logic [TQ_W-1:0]  tq;
    logic             tq_ovf;
  } poly_side_t;

endpackage

>>> src/rtd_if.sv
// Valid/ready channel interfaces of the RTD block: ratio code in, temperature out, config.
// Depends on rtd_pkg for field widths.
interface rtd_in_if #(parameter int unsigned CODE_W = 15);
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] ratio_code;
  modport source (output valid, output ratio_code, input ready);
  modport sink   (input valid, input ratio_code, output ready);
endinterface

interface rtd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rtd_pkg::TEMP_W-1:0] temperature;
  logic [rtd_pkg::RES_W-1:0]         resistance;
  logic                              used_polynomial;
  logic                              saturated;
  modport source (output valid, output temperature, output resistance,
                  output used_polynomial, output saturated, input ready);
  modport sink   (input valid, input temperature, input resistance,
                  input used_polynomial, input saturated, output ready);
endinterface

interface rtd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rtd_pkg::CFG_IDX_W-1:0]     index;
  logic [rtd_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/rtd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Carries a sideband word alongside; no package dependencies.
module rtd_div #(
  parameter int unsigned NUM_W  = 42,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned Q_W    = 29,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic              ovf,
  output logic [SIDE_W-1:0] out_side
);
  localparam int unsigned RW = DEN_W + Q_W;

  logic [Q_W:0]        valid_r;
  logic [RW-1:0]       rem_r   [Q_W+1];
  logic [Q_W-1:0]      quo_r   [Q_W+1];
  logic                ovf_r   [Q_W+1];
  logic [SIDE_W-1:0]   side_r  [Q_W+1];
  logic [RW-1:0]       rem_nxt [Q_W+1];
  logic [Q_W-1:0]      quo_nxt [Q_W+1];
  logic                ovf_in;

  // quotient would not fit in Q_W bits
  assign ovf_in = (num >> Q_W) >= NUM_W'(den);

  always_comb begin
    logic [RW-1:0] dsh;
    logic [RW:0]   diff;
    rem_nxt[0] = RW'(num);
    quo_nxt[0] = '0;
    for (int k = 1; k <= Q_W; k++) begin
      dsh  = RW'(den) << (Q_W - k);
      diff = {1'b0, rem_r[k-1]} - {1'b0, dsh};
      if (diff[RW]) begin
        rem_nxt[k] = rem_r[k-1];
        quo_nxt[k] = quo_r[k-1];
      end else begin
        rem_nxt[k] = diff[RW-1:0];
        quo_nxt[k] = quo_r[k-1] | (Q_W'(1) << (Q_W - k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[Q_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0]  <= ovf_in;
      side_r[0] <= in_side;
      for (int k = 0; k <= Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      for (int k = 1; k <= Q_W; k++) begin
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = valid_r[Q_W];
  assign quo       = quo_r[Q_W];
  assign ovf       = ovf_r[Q_W];
  assign out_side  = side_r[Q_W];

endmodule

>>> src/rtd_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// No package dependencies.
module rtd_sqrt #(
  parameter int unsigned IN_W   = 56,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   arg,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [IN_W/2-1:0] root,
  output logic [SIDE_W-1:0] out_side
);
  localparam int unsigned R_W = IN_W / 2;

  logic [R_W:0]        valid_r;
  logic [IN_W-1:0]     rem_r    [R_W+1];
  logic [R_W-1:0]      root_r   [R_W+1];
  logic [SIDE_W-1:0]   side_r   [R_W+1];
  logic [IN_W-1:0]     rem_nxt  [R_W+1];
  logic [R_W-1:0]      root_nxt [R_W+1];

  // stage k decides root bit R_W-k: try root + 2^i against the remainder
  always_comb begin
    logic [IN_W:0] term;
    int unsigned   i;
    rem_nxt[0]  = arg;
    root_nxt[0] = '0;
    for (int k = 1; k <= R_W; k++) begin
      i    = R_W - k;
      term = ((IN_W+1)'(root_r[k-1]) << (i + 1)) + ((IN_W+1)'(1) << (2 * i));
      if ({1'b0, rem_r[k-1]} >= term) begin
        rem_nxt[k]  = rem_r[k-1] - term[IN_W-1:0];
        root_nxt[k] = root_r[k-1] | (R_W'(1) << i);
      end else begin
        rem_nxt[k]  = rem_r[k-1];
        root_nxt[k] = root_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[R_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 0; k <= R_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
      for (int k = 1; k <= R_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = valid_r[R_W];
  assign root      = root_r[R_W];
  assign out_side  = side_r[R_W];

endmodule

>>> src/rtd_poly.sv
// Fifth-order Horner pipeline for the low-temperature range: multiply stage, then
// shift-and-add stage per coefficient, then rounding. Uses rtd_pkg constants.
module rtd_poly #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [rtd_pkg::X_W-1:0]           x,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic signed [rtd_pkg::TP_W-1:0]   tp,
  output logic [SIDE_W-1:0]                 out_side
);
  import rtd_pkg::*;

  localparam int unsigned NST = 2 * POLY_N;

  logic [NST:0]               valid_r;
  logic [SIDE_W-1:0]          side_r [NST+1];
  logic [X_W-1:0]             x_r    [NST-2];
  logic signed [PROD_W-1:0]   prod_r [POLY_N];
  logic signed [ACC_W-1:0]    acc_r  [POLY_N];
  logic signed [TP_W-1:0]     tp_r;
  logic signed [ACC_W-1:0]    acc_rnd;

  for (genvar j = 0; j < POLY_N; j++) begin : g_step
    logic signed [ACC_W-1:0] acc_in;
    logic [X_W-1:0]          x_in;
    if (j == 0) begin : g_first
      assign acc_in = POLY_K[0];
      assign x_in   = x;
    end else begin : g_next
      assign acc_in = acc_r[j-1];
      assign x_in   = x_r[2*j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[j] <= acc_in * $signed({1'b0, x_in});
        acc_r[j]  <= ACC_W'(prod_r[j] >>> POLY_SH[j]) + POLY_K[j+1];
      end
    end
  end

  assign acc_rnd = acc_r[POLY_N-1] + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      x_r[0]    <= x;
      for (int k = 1; k <= NST; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int k = 1; k < NST - 2; k++) begin
        x_r[k] <= x_r[k-1];
      end
      tp_r <= TP_W'(acc_rnd >>> ROUND_SH);
    end
  end

  assign out_valid = valid_r[NST];
  assign tp        = tp_r;
  assign out_side  = side_r[NST];

endmodule

>>> src/rtd_code_to_temperature.sv
// RTD ratio code to temperature (Callendar-Van Dusen), fully pipelined.
// Uses rtd_pkg, the channel interfaces, rtd_div, rtd_sqrt and rtd_poly.
//
// Channels: in_ch takes one ratio code per word, out_ch returns one word per code
// with temperature (1/256 C), resistance (1/16 ohm), a polynomial-range flag and a
// saturation flag. cfg_ch writes the reference (index 0) and nominal (index 1)
// resistances; it is always ready. It is to be written by the user only while the
// pipeline is empty; the block itself does not enforce this. Throughput: one word
// per cycle while the output is taken. The pipeline is a chain of stages: the R/R0
// divider (30), the polynomial-variable divider (23), the square root (29), the
// Horner pipeline (11) and seven single stages, two of them the numerator and the
// reciprocal multiply of the quadratic branch.
// Stall: all stages advance together; when the output word is held and not taken,
// the whole pipeline holds and in_ch.ready drops. Bubbles advance with valid low.
// Reset (synchronous, rst_n low) clears every stage valid bit and loads the
// register reset values 6880 and 1600.
module rtd_code_to_temperature #(
  parameter int unsigned CODE_BITS = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  rtd_cfg_if.sink        cfg_ch,
  rtd_in_if.sink         in_ch,
  rtd_out_if.source      out_ch
);
  import rtd_pkg::*;

  localparam int unsigned P_W      = CODE_BITS + REF_W;
  localparam int unsigned RQ_SH    = RQ_FRAC - CODE_BITS;
  localparam int unsigned RQ_NUM_W = P_W + RQ_SH;
  localparam int unsigned P25_W    = P_W + 5 + X_SH;

  logic [REF_W-1:0] ref_r;
  logic [NOM_W-1:0] nom_r;
  logic [NOM_W-1:0] den;
  logic             en;

  logic             a_valid_r;
  logic [P_W-1:0]   p_r;
  logic [P_W:0]     p_rnd;
  logic [P25_W-1:0] p25;
  div1_side_t       d1_in, d1_out;
  logic             d1_valid, d1_ovf;
  logic [RQ_W-1:0]  d1_quo;
  div2_side_t       d2_in, d2_out;
  logic             d2_valid, d2_ovf;
  logic [X_W-1:0]   d2_quo;

  logic                   c_valid_r;
  logic signed [UQ_W-1:0] uq_r;
  logic [X_W-1:0]         x_c_r;
  logic [RES_W-1:0]       res_c_r;
  logic                   d_valid_r;
  logic signed [Y_W-1:0]  yp_r;
  logic [X_W-1:0]         x_d_r;
  logic [RES_W-1:0]       res_d_r;
  logic signed [Y_W-1:0]  y_sum;
  logic                   e_valid_r;
  logic [SQ_IN_W-1:0]     y_r;
  sqrt_side_t             e_side_r, s_out;
  logic                   s_valid;
  logic [S_W-1:0]         s_root;

  logic                f_valid_r;
  logic [S_W-1:0]      s_diff;
  logic [WN_W-1:0]     w_num;
  logic [QW_W-1:0]     w_r;
  div3_side_t          f_side_r;
  logic                f_quad;
  logic                g_valid_r;
  logic [QP_W-1:0]     qp_r;
  div3_side_t          g_side_r;
  poly_side_t          p_in, p_out;
  logic                pl_valid;
  logic signed [TP_W-1:0] pl_tp;

  logic                      out_valid_r;
  logic signed [TEMP_W-1:0]  temp_r;
  logic [RES_W-1:0]          res_out_r;
  logic                      poly_r;
  logic                      sat_r;
  logic signed [TEMP_W-1:0]  temp_nxt;
  logic                      sat_nxt;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
      nom_r <= NOM_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_REF: ref_r <= cfg_ch.data[REF_W-1:0];
        CFG_NOM: nom_r <= cfg_ch.data[NOM_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero nominal acts as one
  assign den = (nom_r == '0) ? NOM_W'(1) : nom_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: code times reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= P_W'(CODE_BITS'(in_ch.ratio_code)) * P_W'(ref_r);
    end
  end

  assign p_rnd      = {1'b0, p_r} + ((P_W+1)'(1) << (CODE_BITS - 1));
  assign p25        = (P25_W'(p_r) * P25_W'(X_MUL)) << X_SH;
  assign d1_in.res  = RES_W'(p_rnd >> CODE_BITS);
  assign d1_in.xnum = XNUM_W'(p25 >> CODE_BITS);

  rtd_div #(
    .NUM_W (RQ_NUM_W),
    .DEN_W (NOM_W),
    .Q_W   (RQ_W),
    .SIDE_W($bits(div1_side_t))
  ) u_div_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (a_valid_r),
    .num      ({p_r, RQ_SH'(0)}),
    .den      (den),
    .in_side  (d1_in),
    .out_valid(d1_valid),
    .quo      (d1_quo),
    .ovf      (d1_ovf),
    .out_side (d1_out)
  );

  assign d2_in.res    = d1_out.res;
  assign d2_in.rq     = d1_quo;
  assign d2_in.rq_ovf = d1_ovf;

  rtd_div #(
    .NUM_W (XNUM_W),
    .DEN_W (NOM_W),
    .Q_W   (X_W),
    .SIDE_W($bits(div2_side_t))
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d1_valid),
    .num      (d1_out.xnum),
    .den      (den),
    .in_side  (d2_in),
    .out_valid(d2_valid),
    .quo      (d2_quo),
    .ovf      (d2_ovf),
    .out_side (d2_out)
  );

  // stages C, D, E: u = 1 - r, root argument
  assign y_sum = Y_BASE + yp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= d2_valid;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d2_out.rq_ovf || d2_out.rq > RQ_CLIP) begin
        uq_r <= UQ_MIN;
      end else begin
        uq_r <= UQ_ONE - $signed({1'b0, d2_out.rq});
      end
      x_c_r   <= (d2_ovf || d2_quo > X_MAX) ? X_MAX : d2_quo;
      res_c_r <= d2_out.res;

      yp_r    <= CVD_4B * uq_r;
      x_d_r   <= x_c_r;
      res_d_r <= res_c_r;

      y_r               <= SQ_IN_W'(y_sum);
      e_side_r.res      <= res_d_r;
      e_side_r.x        <= x_d_r;
      e_side_r.y_nonneg <= !y_sum[Y_W-1];
    end
  end

  rtd_sqrt #(
    .IN_W  (SQ_IN_W),
    .SIDE_W($bits(sqrt_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (e_valid_r),
    .arg      (y_r),
    .in_side  (e_side_r),
    .out_valid(s_valid),
    .root     (s_root),
    .out_side (s_out)
  );

  // stage F: quadratic branch numerator, reduced to (5*a + 462) / 4
  assign f_quad = s_out.y_nonneg && (s_root <= CVD_AS);
  assign s_diff = CVD_AS - s_root;
  assign w_num  = (WN_W'(s_diff) << 2) + WN_W'(s_diff) + Q_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= s_valid;
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= f_quad ? QW_W'(w_num >> 2) : '0;
      f_side_r.res  <= s_out.res;
      f_side_r.x    <= s_out.x;
      f_side_r.quad <= f_quad;

      // stage G: divide by 231 through the reciprocal
      qp_r     <= QP_W'(w_r) * QP_W'(Q_RECIP);
      g_side_r <= f_side_r;
    end
  end

  assign p_in.res    = g_side_r.res;
  assign p_in.quad   = g_side_r.quad;
  assign p_in.tq     = qp_r[Q_RECIP_SH +: TQ_W];
  assign p_in.tq_ovf = |qp_r[QP_W-1:Q_RECIP_SH+TQ_W];

  rtd_poly #(
    .SIDE_W($bits(poly_side_t))
  ) u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (g_valid_r),
    .x        (g_side_r.x),
    .in_side  (p_in),
    .out_valid(pl_valid),
    .tp       (pl_tp),
    .out_side (p_out)
  );

  // output stage: pick the branch and clip
  always_comb begin
    if (p_out.quad) begin
      temp_nxt = p_out.tq_ovf ? T_MAX : $signed({1'b0, p_out.tq});
      sat_nxt  = p_out.tq_ovf;
    end else if (pl_tp > T_MAX) begin
      temp_nxt = T_MAX;
      sat_nxt  = 1'b1;
    end else if (pl_tp < T_MIN) begin
      temp_nxt = T_MIN;
      sat_nxt  = 1'b1;
    end else begin
      temp_nxt = TEMP_W'(pl_tp);
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r    <= temp_nxt;
      res_out_r <= p_out.res;
      poly_r    <= !p_out.quad;
      sat_r     <= sat_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.temperature     = temp_r;
  assign out_ch.resistance      = res_out_r;
  assign out_ch.used_polynomial = poly_r;
  assign out_ch.saturated       = sat_r;

  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      out_ch.temperature == T_MAX || out_ch.temperature == T_MIN)
    else $error("saturated word not at a rail");

  a_quad_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.used_polynomial |-> !out_ch.temperature[TEMP_W-1])
    else $error("quadratic branch gave a negative temperature");

  a_quad_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.used_polynomial && out_ch.saturated |->
      out_ch.temperature == T_MAX)
    else $error("quadratic branch clipped low");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

>>> tb/rtd_tb_if.sv
`timescale 1ns / 100ps
// Testbench view of the RTD channel interfaces.
// The channel interfaces come with the RTL (src/rtd_if.sv); this file holds rtd_tb_pkg.
package rtd_tb_pkg;
  localparam int unsigned DRAIN_CYCLES = 140;
endpackage

>>> tb/rtd_code_to_temperature_test.sv
`timescale 1ns / 100ps
// Testbench for rtd_code_to_temperature: directed and random ratio codes under
// several reference/nominal settings, checked against an integer predictor.
// Depends on rtd_pkg, rtd_tb_pkg and the channel interfaces of the block.
module rtd_code_to_temperature_test;
  import rtd_pkg::*;
  import rtd_tb_pkg::*;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    logic [RES_W-1:0]         resistance;
    logic                     used_polynomial;
    logic                     saturated;
  } reading_t;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [REF_W-1:0] ref_ohms = REF_RESET;
  logic [NOM_W-1:0] nom_ohms = NOM_RESET;
  reading_t pending_readings[$];
  int errors = 0;

  rtd_cfg_if cfg_ch ();
  rtd_in_if #(.CODE_W(15)) in_ch ();
  rtd_out_if out_ch ();

  rtd_code_to_temperature #(.CODE_BITS(15)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint horner_step(longint acc, longint x, int sh, longint k);
    longint prod;
    prod = acc * x;
    return (prod >>> sh) + k;
  endfunction

  function automatic reading_t convert_code(logic [14:0] code);
    reading_t rd;
    longint unsigned p, nd, rq, xu, s;
    longint uq, y, t, acc;
    logic poly;
    p = longint'(code) * longint'(ref_ohms);
    nd = longint'((nom_ohms == 0) ? 16'd1 : nom_ohms) << 15;
    rd.resistance = RES_W'((p + (64'd1 << 14)) >> 15);
    rq = (p << 24) / nd;
    uq = (64'sd1 <<< 24) - longint'(rq);
    if (uq < -(64'sd16 <<< 24)) uq = -(64'sd16 <<< 24);
    y = 64'sd1527480889 * (64'sd1 <<< 24) + 64'sd231000000 * uq;
    poly = 1'b1;
    t = 0;
    if (y >= 0) begin
      s = int_sqrt(y);
      if (s <= 160083968) begin
        t = ((160083968 - longint'(s)) * 1000 + 92400) / 184800;
        poly = 1'b0;
      end
    end
    if (poly) begin
      xu = (p * 409600) / nd;
      if (xu > (64'd512 << 12)) xu = 64'd512 << 12;
      acc = 64'sd719830322984;
      acc = horner_step(acc, xu, 21, -64'sd259942294115);
      acc = horner_step(acc, xu, 21, -64'sd86937487207);
      acc = horner_step(acc, xu, 22, 64'sd45491633892);
      acc = horner_step(acc, xu, 21, 64'sd76374826444);
      acc = horner_step(acc, xu, 21, -64'sd16241687265);
      t = (acc + (64'sd1 <<< 17)) >>> 18;
    end
    rd.saturated = 1'b0;
    if (t > 262143) begin
      t = 262143;
      rd.saturated = 1'b1;
    end else if (t < -65536) begin
      t = -65536;
      rd.saturated = 1'b1;
    end
    rd.temperature = TEMP_W'(t);
    rd.used_polynomial = poly;
    return rd;
  endfunction

  // sink side: random stalls, check every word against the oldest prediction
  initial begin
    reading_t exp_rd;
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    while (1) begin
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected word temp=%0d res=%0d", $time,
                 out_ch.temperature, out_ch.resistance);
        errors++;
      end else begin
        exp_rd = pending_readings.pop_front();
        if (out_ch.temperature !== exp_rd.temperature ||
            out_ch.resistance !== exp_rd.resistance ||
            out_ch.used_polynomial !== exp_rd.used_polynomial ||
            out_ch.saturated !== exp_rd.saturated) begin
          $display("%0t: expected temp=%0d res=%0d poly=%0b sat=%0b", $time,
                   exp_rd.temperature, exp_rd.resistance, exp_rd.used_polynomial,
                   exp_rd.saturated);
          $display("%0t: actual   temp=%0d res=%0d poly=%0b sat=%0b", $time,
                   out_ch.temperature, out_ch.resistance, out_ch.used_polynomial,
                   out_ch.saturated);
          errors++;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end
  end

  task automatic send_code(logic [14:0] code, bit idle_ok = 1);
    int gap;
    gap = (!idle_ok || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ratio_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    pending_readings.push_back(convert_code(code));
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_REF) ref_ohms = value;
    else if (idx == CFG_NOM) nom_ohms = value[NOM_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_directed_codes();
    logic [14:0] codes[] = '{15'd0, 15'd1, 15'h7FFF, 15'h4000, 15'h3FFF, 15'h2000,
                              15'd7620, 15'd7621, 15'd5000, 15'd2500, 15'd9000,
                              15'd12000, 15'h5555, 15'h2AAA};
    foreach (codes[i]) send_code(codes[i], 0);
    end_burst();
  endtask

  task automatic test_random_codes(int count);
    repeat (count) send_code(15'($urandom));
    end_burst();
  endtask

  task automatic test_register_extremes();
    // zero reference and zero nominal are special; then the extremes of each range
    write_reg(CFG_REF, 18'd0);
    test_directed_codes();
    write_reg(CFG_REF, 18'h3FFFF);
    write_reg(CFG_NOM, 18'd0);
    test_directed_codes();
    write_reg(CFG_NOM, 18'hFFFF);
    test_directed_codes();
    write_reg(CFG_REF, 18'd16);
    write_reg(CFG_NOM, 18'd16);
    test_random_codes(40);
    write_reg(CFG_REF, 18'd3);
    write_reg(CFG_SPARE, 18'h15555);  // unused index, must be ignored
    test_random_codes(20);
  endtask

  task automatic test_random_settings();
    repeat (6) begin
      write_reg(CFG_REF, CFG_DATA_W'($urandom_range(16, 262143)));
      write_reg(CFG_NOM, CFG_DATA_W'($urandom_range(16, 65535)));
      test_random_codes(60);
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_REF;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.ratio_code = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_codes();
    test_random_codes(150);
    test_register_extremes();
    write_reg(CFG_REF, REF_RESET);
    write_reg(CFG_NOM, CFG_DATA_W'(NOM_RESET));
    test_random_settings();
    write_reg(CFG_REF, 18'd6880);
    write_reg(CFG_NOM, 18'd1600);
    test_random_codes(40);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("** rtd_code_to_temperature: PASSED **");
    else $display("** rtd_code_to_temperature: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** rtd_code_to_temperature: FAILED **");
    $finish;
  end

endmodule
